// File: hdl/pfc_pkg.sv
package pfc_pkg;

   localparam int BYTE_W = 8;
   localparam int PIX_W  = 16;
   localparam int IDX_W  = 21;

   typedef enum logic [2:0] {
      SRC_RGB565LE = 3'd0,
      SRC_RGB565BE = 3'd1,
      SRC_RGB888   = 3'd2,
      SRC_BGR888   = 3'd3,
      SRC_GRAY8    = 3'd4,
      SRC_YUYV     = 3'd5,
      SRC_UYVY     = 3'd6
   } src_fmt_type;

   typedef enum logic [1:0] {
      REG_SRC_FMT = 2'd0,
      REG_TGT_FMT = 2'd1,
      REG_PIX_CNT = 2'd2
   } reg_idx_type;

   typedef struct packed {
      src_fmt_type        in_fmt;
      logic               target_gray;
      logic [IDX_W-1:0]   frame_len;
      logic               restart;
   } cfg_type;

   // one complete source unit: earlier bytes shift through p2 toward p0, newest byte in b
   typedef struct packed {
      logic [BYTE_W-1:0]  p0;
      logic [BYTE_W-1:0]  p1;
      logic [BYTE_W-1:0]  p2;
      logic [BYTE_W-1:0]  b;
      src_fmt_type        fmt;
      logic               gray;
      logic               pair;
      logic               lone;
      logic               lone_zero;
      logic               last0;
      logic               last1;
   } unit_type;

   typedef struct packed {
      logic [PIX_W-1:0]   pix0;
      logic [PIX_W-1:0]   pix1;
      logic               pair;
      logic               lone;
      logic               lone_zero;
      logic               last0;
      logic               last1;
   } pix_pair_type;

endpackage

// File: hdl/pfc_if.sv
interface pfc_req_if;
   logic                        valid;
   logic                        ready;
   logic [pfc_pkg::BYTE_W-1:0]  data_byte;
   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface pfc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [pfc_pkg::PIX_W-1:0]   pixel_value;
   logic                        last_pixel;
   modport source (output valid, output pixel_value, output last_pixel, input ready);
   modport sink   (input valid, input pixel_value, input last_pixel, output ready);
endinterface

// File: hdl/pixel_format_converter.sv
// channel   dir   beat carries                     handshake
// req_ch    in    data_byte[7:0]                   valid/ready
// rsp_ch    out   pixel_value[15:0], last_pixel    valid/ready
// apb       in    psel/penable/pwrite/paddr[3:0]   pready tied high
//
// One byte per cycle unless input stalls; a pixel, once its last byte is taken,
// passes the unit register, product stage, pack stage and 4-entry output queue.
// A YUV pair adds two queue beats; they drain one per cycle while ready is high.
// Input stalls only while three or more result beats wait in the output queue.
// Synchronous reset restores the register defaults and empties the pipeline;
// a write to any of the three defined registers restarts the frame.
module pixel_format_converter #(
   parameter int MAX_PIXELS = 2073600
) (
   input  logic         clock,
   input  logic         reset,
   pfc_req_if.sink      req_ch,
   pfc_rsp_if.source    rsp_ch,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [3:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);
   import pfc_pkg::*;

   cfg_type       cfg;
   unit_type      unit;
   pix_pair_type  pix;
   logic          adv, unit_valid, pix_valid, beat;

   assign pready       = 1'b1;
   assign req_ch.ready = adv;
   assign beat         = req_ch.valid & adv;

   pfc_csr #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   pfc_unpack u_unpack (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .beat       (beat),
      .data_byte  (req_ch.data_byte),
      .cfg        (cfg),
      .unit_valid (unit_valid),
      .unit       (unit)
   );

   pfc_convert u_convert (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .unit_valid (unit_valid),
      .unit       (unit),
      .pix_valid  (pix_valid),
      .pix        (pix)
   );

   pfc_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .pix_valid (pix_valid),
      .pix       (pix),
      .out_ready (rsp_ch.ready),
      .adv       (adv),
      .out_valid (rsp_ch.valid),
      .out_value (rsp_ch.pixel_value),
      .out_last  (rsp_ch.last_pixel)
   );

endmodule

// File: hdl/pfc_csr.sv
module pfc_csr #(
   parameter int MAX_PIXELS = 2073600
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output pfc_pkg::cfg_type  cfg
);
   import pfc_pkg::*;

   localparam logic [24:0] MaxPix = 25'(MAX_PIXELS);

   src_fmt_type       src_ff, src_in;
   logic              gray_ff, gray_in;
   logic [IDX_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  len_ff, len_in;
   logic              restart;
   logic              wr;
   logic [IDX_W-1:0]  wcount;

   assign wr     = psel & penable & pwrite;
   assign wcount = pwdata[IDX_W-1:0];

   always_comb begin
      src_in   = src_ff;
      gray_in  = gray_ff;
      count_in = count_ff;
      len_in   = len_ff;
      restart  = 1'b0;
      if (wr) begin
         unique case (reg_idx_type'(paddr[3:2]))
            REG_SRC_FMT: begin
               src_in  = src_fmt_type'(pwdata[2:0]);
               restart = 1'b1;
            end
            REG_TGT_FMT: begin
               gray_in = pwdata[0];
               restart = 1'b1;
            end
            REG_PIX_CNT: begin
               count_in = wcount;
               restart  = 1'b1;
               if (wcount == '0) begin
                  len_in = IDX_W'(1);
               end else if ({4'd0, wcount} > MaxPix) begin
                  len_in = MaxPix[IDX_W-1:0];
               end else begin
                  len_in = wcount;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff   <= SRC_RGB565LE;
         gray_ff  <= 1'b0;
         count_ff <= IDX_W'(1);
         len_ff   <= IDX_W'(1);
      end else begin
         src_ff   <= src_in;
         gray_ff  <= gray_in;
         count_ff <= count_in;
         len_ff   <= len_in;
      end
   end

   always_comb begin
      unique case (reg_idx_type'(paddr[3:2]))
         REG_SRC_FMT: prdata = {29'd0, src_ff};
         REG_TGT_FMT: prdata = {31'd0, gray_ff};
         REG_PIX_CNT: prdata = {11'd0, count_ff};
         default:     prdata = '0;
      endcase
   end

   assign cfg.in_fmt      = src_ff;
   assign cfg.target_gray = gray_ff;
   assign cfg.frame_len   = len_ff;
   assign cfg.restart     = restart;

endmodule

// File: hdl/pfc_unpack.sv
module pfc_unpack (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        beat,
   input  logic [pfc_pkg::BYTE_W-1:0]  data_byte,
   input  pfc_pkg::cfg_type            cfg,
   output logic                        unit_valid,
   output pfc_pkg::unit_type           unit
);
   import pfc_pkg::*;

   logic [1:0]        phase_ff, phase_in;
   logic [23:0]       held_ff, held_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              valid_ff, valid_in;
   unit_type          unit_ff, unit_in;

   logic              yuv, lone, last0, last1, fmt_ok, done, pair;
   logic [2:0]        need;
   logic [IDX_W:0]    idx_p1, idx1_p1;
   logic [IDX_W-1:0]  idx1, idx_next;

   assign yuv    = (cfg.in_fmt == SRC_YUYV) || (cfg.in_fmt == SRC_UYVY);
   assign idx_p1 = {1'b0, idx_ff} + (IDX_W+1)'(1);
   assign last0  = idx_p1 >= {1'b0, cfg.frame_len};
   assign lone   = yuv & cfg.frame_len[0] & last0;
   assign pair   = yuv & ~lone;
   assign idx1   = last0 ? '0 : idx_p1[IDX_W-1:0];
   assign idx1_p1 = {1'b0, idx1} + (IDX_W+1)'(1);
   assign last1  = idx1_p1 >= {1'b0, cfg.frame_len};
   assign idx_next = pair ? (last1 ? '0 : idx1_p1[IDX_W-1:0]) : idx1;

   always_comb begin
      fmt_ok = 1'b1;
      unique case (cfg.in_fmt)
         SRC_RGB565LE, SRC_RGB565BE: need = 3'd2;
         SRC_RGB888, SRC_BGR888:     need = 3'd3;
         SRC_GRAY8:                  need = 3'd1;
         SRC_YUYV, SRC_UYVY:         need = 3'd4;
         default: begin
            need   = 3'd1;
            fmt_ok = 1'b0;
         end
      endcase
      if (lone) begin
         need = 3'd2;
      end
   end

   assign done = ({1'b0, phase_ff} + 3'd1) >= need;

   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (adv) begin
         valid_in = 1'b0;
         if (beat && fmt_ok) begin
            if (done) begin
               valid_in = 1'b1;
               phase_in = '0;
               held_in  = '0;
               idx_in   = idx_next;
            end else begin
               phase_in = phase_ff + 2'd1;
               held_in  = {held_ff[15:0], data_byte};
            end
         end
      end
      if (cfg.restart) begin
         phase_in = '0;
         held_in  = '0;
         idx_in   = '0;
      end
   end

   always_comb begin
      unit_in.p0        = held_ff[23:16];
      unit_in.p1        = held_ff[15:8];
      unit_in.p2        = held_ff[7:0];
      unit_in.b         = data_byte;
      unit_in.fmt       = cfg.in_fmt;
      unit_in.gray      = cfg.target_gray;
      unit_in.pair      = pair;
      unit_in.lone      = lone;
      unit_in.lone_zero = cfg.frame_len == IDX_W'(1);
      unit_in.last0     = last0;
      unit_in.last1     = last1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         held_ff  <= '0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && beat && fmt_ok && done) begin
         unit_ff <= unit_in;
      end
   end

   assign unit_valid = valid_ff;
   assign unit       = unit_ff;

endmodule

// File: hdl/pfc_convert.sv
module pfc_convert (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    unit_valid,
   input  pfc_pkg::unit_type       unit,
   output logic                    pix_valid,
   output pfc_pkg::pix_pair_type   pix
);
   import pfc_pkg::*;

   typedef enum logic [1:0] {
      MODE_DIRECT = 2'd0,
      MODE_LUMA   = 2'd1,
      MODE_YUV    = 2'd2
   } mode_type;

   typedef struct packed {
      mode_type            mode;
      logic [PIX_W-1:0]    direct0;
      logic [PIX_W-1:0]    direct1;
      logic [15:0]         lr;
      logic [15:0]         lg;
      logic [15:0]         lb;
      logic signed [19:0]  c0m;
      logic signed [19:0]  c1m;
      logic signed [19:0]  rem;
      logic signed [19:0]  gdm;
      logic signed [19:0]  gem;
      logic signed [19:0]  bdm;
      logic                pair;
      logic                lone;
      logic                lone_zero;
      logic                last0;
      logic                last1;
   } prod_type;

   function automatic logic [7:0] clip8(input logic signed [19:0] v);
      logic [7:0] r;
      if (v[19]) begin
         r = 8'd0;
      end else if (v[18:16] != 3'd0) begin
         r = 8'hFF;
      end else begin
         r = v[15:8];
      end
      return r;
   endfunction

   function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

   prod_type            prod_ff, prod_in;
   logic                prod_valid_ff;
   pix_pair_type        pix_ff, pix_in;
   logic                pix_valid_ff;

   logic [15:0]         px;
   logic [7:0]          r8, g8, b8, y0, y1, u, v;
   logic signed [19:0]  c0, c1, d, e;

   // stage 1: channel select and constant products
   always_comb begin
      px = '0;
      r8 = '0;
      g8 = '0;
      b8 = '0;
      y0 = unit.p1;
      u  = unit.p0;
      y1 = unit.b;
      v  = unit.p2;
      prod_in.mode    = MODE_DIRECT;
      prod_in.direct0 = '0;
      prod_in.direct1 = '0;
      unique case (unit.fmt)
         SRC_RGB565LE, SRC_RGB565BE: begin
            px = (unit.fmt == SRC_RGB565LE) ? {unit.b, unit.p2} : {unit.p2, unit.b};
            r8 = {px[15:11], px[15:13]};
            g8 = {px[10:5], px[10:9]};
            b8 = {px[4:0], px[4:2]};
            prod_in.mode    = unit.gray ? MODE_LUMA : MODE_DIRECT;
            prod_in.direct0 = px;
         end
         SRC_RGB888, SRC_BGR888: begin
            r8 = (unit.fmt == SRC_RGB888) ? unit.p1 : unit.b;
            g8 = unit.p2;
            b8 = (unit.fmt == SRC_RGB888) ? unit.b : unit.p1;
            prod_in.mode    = unit.gray ? MODE_LUMA : MODE_DIRECT;
            prod_in.direct0 = pack565(r8, g8, b8);
         end
         SRC_GRAY8: begin
            prod_in.direct0 = unit.gray ? {8'd0, unit.b} : pack565(unit.b, unit.b, unit.b);
         end
         SRC_YUYV, SRC_UYVY: begin
            if (unit.fmt == SRC_YUYV) begin
               y0 = unit.p0;
               u  = unit.p1;
               y1 = unit.p2;
               v  = unit.b;
            end
            prod_in.mode    = unit.gray ? MODE_DIRECT : MODE_YUV;
            prod_in.direct0 = {8'd0, y0};
            prod_in.direct1 = {8'd0, y1};
         end
         default: ;
      endcase
      if (unit.lone) begin
         prod_in.mode = MODE_DIRECT;
      end
      c0 = (y0 >= 8'd16) ? $signed({12'd0, y0}) - 20'sd16 : 20'sd0;
      c1 = (y1 >= 8'd16) ? $signed({12'd0, y1}) - 20'sd16 : 20'sd0;
      d  = $signed({12'd0, u}) - 20'sd128;
      e  = $signed({12'd0, v}) - 20'sd128;
      prod_in.lr  = {8'd0, r8} * 16'd77;
      prod_in.lg  = {8'd0, g8} * 16'd150;
      prod_in.lb  = {8'd0, b8} * 16'd29;
      prod_in.c0m = c0 * 20'sd298;
      prod_in.c1m = c1 * 20'sd298;
      prod_in.rem = e * 20'sd409;
      prod_in.gdm = d * 20'sd100;
      prod_in.gem = e * 20'sd208;
      prod_in.bdm = d * 20'sd516;
      prod_in.pair      = unit.pair;
      prod_in.lone      = unit.lone;
      prod_in.lone_zero = unit.lone_zero;
      prod_in.last0     = unit.last0;
      prod_in.last1     = unit.last1;
   end

   // stage 2: sums, clipping and packing
   logic [15:0]         luma_sum;
   logic signed [19:0]  r0s, g0s, b0s, r1s, g1s, b1s;

   always_comb begin
      luma_sum = prod_ff.lr + prod_ff.lg + prod_ff.lb;
      r0s = prod_ff.c0m + prod_ff.rem + 20'sd128;
      g0s = prod_ff.c0m - prod_ff.gdm - prod_ff.gem + 20'sd128;
      b0s = prod_ff.c0m + prod_ff.bdm + 20'sd128;
      r1s = prod_ff.c1m + prod_ff.rem + 20'sd128;
      g1s = prod_ff.c1m - prod_ff.gdm - prod_ff.gem + 20'sd128;
      b1s = prod_ff.c1m + prod_ff.bdm + 20'sd128;
      unique case (prod_ff.mode)
         MODE_LUMA: begin
            pix_in.pix0 = {8'd0, luma_sum[15:8]};
            pix_in.pix1 = '0;
         end
         MODE_YUV: begin
            pix_in.pix0 = pack565(clip8(r0s), clip8(g0s), clip8(b0s));
            pix_in.pix1 = pack565(clip8(r1s), clip8(g1s), clip8(b1s));
         end
         default: begin
            pix_in.pix0 = prod_ff.direct0;
            pix_in.pix1 = prod_ff.direct1;
         end
      endcase
      pix_in.pair      = prod_ff.pair;
      pix_in.lone      = prod_ff.lone;
      pix_in.lone_zero = prod_ff.lone_zero;
      pix_in.last0     = prod_ff.last0;
      pix_in.last1     = prod_ff.last1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         pix_valid_ff  <= 1'b0;
      end else if (adv) begin
         prod_valid_ff <= unit_valid;
         pix_valid_ff  <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         pix_ff  <= pix_in;
      end
   end

   assign pix_valid = pix_valid_ff;
   assign pix       = pix_ff;

endmodule

// File: hdl/pfc_out_queue.sv
module pfc_out_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        pix_valid,
   input  pfc_pkg::pix_pair_type       pix,
   input  logic                        out_ready,
   output logic                        adv,
   output logic                        out_valid,
   output logic [pfc_pkg::PIX_W-1:0]   out_value,
   output logic                        out_last
);
   import pfc_pkg::*;

   localparam int Depth = 4;
   localparam int PtrW  = $clog2(Depth);

   logic [PIX_W-1:0]  val_mem [Depth];
   logic              last_mem [Depth];

   logic [PtrW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrW:0]     cnt_ff, cnt_in;
   logic [PIX_W-1:0]  prev_ff, prev_in;
   logic              push, pop;
   logic [PIX_W-1:0]  val0;
   logic [PtrW-1:0]   wr_next;

   // pipeline advances only while two slots are free, enough for a YUV pair
   assign adv     = cnt_ff <= (PtrW+1)'(Depth - 2);
   assign push    = pix_valid & adv;
   assign out_valid = cnt_ff != '0;
   assign pop     = out_valid & out_ready;
   assign wr_next = wr_ff + PtrW'(1);
   assign val0    = pix.lone ? (pix.lone_zero ? '0 : prev_ff) : pix.pix0;

   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      cnt_in  = cnt_ff;
      prev_in = prev_ff;
      if (push) begin
         wr_in   = pix.pair ? wr_ff + PtrW'(2) : wr_next;
         cnt_in  = cnt_ff + (pix.pair ? (PtrW+1)'(2) : (PtrW+1)'(1));
         prev_in = pix.pair ? pix.pix1 : val0;
      end
      if (pop) begin
         rd_in  = rd_ff + PtrW'(1);
         cnt_in = cnt_in - (PtrW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         cnt_ff  <= '0;
         prev_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         cnt_ff  <= cnt_in;
         prev_ff <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         val_mem[wr_ff]  <= val0;
         last_mem[wr_ff] <= pix.last0;
         if (pix.pair) begin
            val_mem[wr_next]  <= pix.pix1;
            last_mem[wr_next] <= pix.last1;
         end
      end
   end

   assign out_value = val_mem[rd_ff];
   assign out_last  = last_mem[rd_ff];

endmodule

// File: hdl/pfc_checker.sv
module pfc_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input logic [15:0]  pixel_value,
   input logic         last_pixel,
   input logic [3:0]   paddr,
   input logic [31:0]  prdata
);
   import pfc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(pixel_value) && $stable(last_pixel))
      else $error("rsp payload changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp beat pending right after reset");

   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req stalled with empty output");

   a_reset_count: assert property (@(posedge clock)
      $past(reset) && paddr == {REG_PIX_CNT, 2'b00} |-> prdata == 32'd1)
      else $error("pixel count not one after reset");

endmodule

bind pixel_format_converter pfc_checker u_pfc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .pixel_value (rsp_ch.pixel_value),
   .last_pixel  (rsp_ch.last_pixel),
   .paddr       (paddr),
   .prdata      (prdata)
);
